FILE: rtl/pid_pkg.sv
// pid_pkg: shared types and codes for the PID step block.
// Used by pid_controller_step and its testbench; no dependencies.
package pid_pkg;
	typedef enum logic [1:0] {
		OP_STEP_SP  = 2'd0,
		OP_STEP_ERR = 2'd1,
		OP_CLEAR    = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_GAIN_P  = 3'd0,
		REG_GAIN_I  = 3'd1,
		REG_GAIN_D  = 3'd2,
		REG_DEAD    = 3'd3,
		REG_IBOUND  = 3'd4,
		REG_OBOUND  = 3'd5,
		REG_SBOUND  = 3'd6,
		REG_SMOOTH  = 3'd7
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL_P,
		ST_MUL_DT,
		ST_INT,
		ST_MUL_I,
		ST_DIV,
		ST_SLOPE,
		ST_MUL_A,
		ST_MUL_B,
		ST_FILT,
		ST_MUL_D,
		ST_SUM,
		ST_OUT
	} state_t;

	localparam int ALPHA_BITS = 16;
	localparam logic [15:0] ALPHA_MAX = 16'd65470;
endpackage

FILE: rtl/pid_mul.sv
// pid_mul: shared signed multiplier with shift, truncation toward zero and
// saturation. One registered product per cycle. Depends on nothing.
module pid_mul #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic signed [W:0]   a,
	input  logic signed [W:0]   b,
	input  logic [5:0]          sh,
	output logic signed [W-1:0] p_q
);
	localparam int PW = 2 * W + 2;
	logic signed [PW-1:0] prod;
	logic [PW-1:0] mg, sm;
	logic neg;
	logic [W-1:0] lim;
	logic signed [W-1:0] r;

	always_comb begin
		prod = PW'(a) * PW'(b);
		neg  = prod[PW-1];
		mg   = neg ? (~prod + PW'(1)) : prod;
		sm   = mg >> sh;
		lim  = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		if (sm > PW'(lim))
			r = neg ? $signed(lim) : $signed(lim);
		else
			r = neg ? $signed(~sm[W-1:0] + W'(1)) : $signed(sm[W-1:0]);
	end

	always_ff @(posedge clk) begin
		p_q <= r;
	end
endmodule

FILE: rtl/pid_div.sv
// pid_div: serial restoring divider, one quotient bit per cycle, for
// (|n| << F) / d with saturation at the signed range. Depends on nothing.
module pid_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] n,
	input  logic [W-1:0]        d,
	output logic                done,
	output logic signed [W-1:0] q_out
);
	localparam int NB = W + F;
	localparam int CW = $clog2(NB + 1);
	logic [NB-1:0] num_q, quo_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  den_q;
	logic          neg_q, busy_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]    rs, rt;
	logic [W-1:0]  mg;

	assign mg = n[W-1] ? (~n + W'(1)) : n;
	assign rs = {rem_q[W-1:0], num_q[NB-1]};
	assign rt = rs - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {mg, {F{1'b0}}};
			quo_q <= '0;
			rem_q <= '0;
			den_q <= d;
			neg_q <= n[W-1];
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (!rt[W]) begin
				rem_q <= rt;
				quo_q <= {quo_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= rs;
				quo_q <= {quo_q[NB-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (neg_q) begin
			if (quo_q >= NB'({1'b1, {(W-1){1'b0}}}))
				q_out = {1'b1, {(W-1){1'b0}}};
			else
				q_out = $signed(~quo_q[W-1:0] + W'(1));
		end else begin
			if (quo_q > NB'({1'b0, {(W-1){1'b1}}}))
				q_out = {1'b0, {(W-1){1'b1}}};
			else
				q_out = $signed(quo_q[W-1:0]);
		end
	end
endmodule

FILE: rtl/pid_controller_step.sv
// pid_controller_step: top level, sequencer around the shared multiplier
// and the serial divider. Depends on pid_pkg, pid_mul, pid_div.
//
// Usage: items arrive on s_tvalid/s_tready/s_tdata/s_tuser, one drive
// value per item leaves on m_tvalid/m_tready/m_tdata. s_tready is high
// only while the sequencer is idle; one item is in flight at a time.
// A step runs through the sequencer states ERR, MUL_P, MUL_DT, INT, MUL_I,
// DIV (waiting on the divider), SLOPE, MUL_A, MUL_B, FILT, MUL_D, SUM and
// OUT, paced by the one-bit-per-cycle divider and the single shared
// multiplier (six products per step). Clear and unused codes go from ERR
// straight to OUT, deadband steps from MUL_P; OUT raises m_tvalid.
// The result waits in the output register until m_tready; the next
// item is taken once that transfer is done.
// Reset clears the state, the configuration to its defaults and the
// sequencer to idle. Configuration writes (cfg_we, cfg_index, cfg_data)
// take effect at once and must come only while the block is idle.
module pid_controller_step #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [DATA_WIDTH-1:0]   cfg_data,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// target, measured, direct_error, time_step from bit 0
	input  logic [4*DATA_WIDTH-1:0] s_tdata,
	// operation
	input  logic [1:0]              s_tuser,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// drive
	output logic [DATA_WIDTH-1:0]   m_tdata
);
	localparam int W = DATA_WIDTH;
	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	pid_pkg::state_t st_q, st_d;
	logic signed [W-1:0] kp_q, ki_q, kd_q;
	logic [W-2:0] dz_q, ib_q, ob_q, sb_q;
	logic [15:0] al_q;
	logic signed [W-1:0] isum_q, last_q, filt_q, err_q, p_q, i_q, acc_q, slope_q;
	logic lv_q;
	logic [W-1:0] dt_q;
	logic signed [W-1:0] tgt_q, meas_q, dir_q;
	logic [1:0] op_q;
	logic signed [W:0] ma, mb;
	logic [5:0] msh;
	logic signed [W-1:0] mp;
	logic dstart, ddone;
	logic signed [W-1:0] dq, dn;
	logic [W-1:0] emag;

	function automatic logic signed [W-1:0] sadd(logic signed [W-1:0] a,
		logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) return s[W] ? SMIN : SMAX;
		return s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] ssub(logic signed [W-1:0] a,
		logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1]) return s[W] ? SMIN : SMAX;
		return s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] clampa(logic signed [W-1:0] v,
		logic [W-2:0] l);
		logic signed [W-1:0] lp;
		lp = $signed({1'b0, l});
		if (v > lp) return lp;
		if (v < -lp) return -lp;
		return v;
	endfunction

	pid_mul #(.W(W)) u_mul (.clk(clk), .a(ma), .b(mb), .sh(msh), .p_q(mp));
	pid_div #(.W(W), .F(FRAC_BITS)) u_div (.clk(clk), .arst_n(arst_n),
		.start(dstart), .n(dn), .d(dt_q), .done(ddone), .q_out(dq));

	assign s_tready = (st_q == pid_pkg::ST_IDLE) && !m_tvalid;
	assign emag = err_q[W-1] ? W'(~err_q + W'(1)) : W'(err_q);
	assign dn = ssub(err_q, last_q);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			pid_pkg::ST_IDLE:   if (s_tvalid && s_tready) st_d = pid_pkg::ST_ERR;
			pid_pkg::ST_ERR: begin
				if (op_q == pid_pkg::OP_CLEAR || op_q == pid_pkg::OP_NONE)
					st_d = pid_pkg::ST_OUT;
				else
					st_d = pid_pkg::ST_MUL_P;
			end
			pid_pkg::ST_MUL_P: begin
				if (emag < {1'b0, dz_q}) st_d = pid_pkg::ST_OUT;
				else st_d = pid_pkg::ST_MUL_DT;
			end
			pid_pkg::ST_MUL_DT: st_d = pid_pkg::ST_INT;
			pid_pkg::ST_INT:    st_d = pid_pkg::ST_MUL_I;
			pid_pkg::ST_MUL_I:  st_d = pid_pkg::ST_DIV;
			pid_pkg::ST_DIV:    if (ddone) st_d = pid_pkg::ST_SLOPE;
			pid_pkg::ST_SLOPE:  st_d = pid_pkg::ST_MUL_A;
			pid_pkg::ST_MUL_A:  st_d = pid_pkg::ST_MUL_B;
			pid_pkg::ST_MUL_B:  st_d = pid_pkg::ST_FILT;
			pid_pkg::ST_FILT:   st_d = pid_pkg::ST_MUL_D;
			pid_pkg::ST_MUL_D:  st_d = pid_pkg::ST_SUM;
			pid_pkg::ST_SUM:    st_d = pid_pkg::ST_OUT;
			pid_pkg::ST_OUT:    st_d = pid_pkg::ST_IDLE;
			default:            st_d = pid_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ma = '0;
		mb = '0;
		msh = 6'(FRAC_BITS);
		dstart = 1'b0;
		unique case (st_q)
			pid_pkg::ST_MUL_P: begin
				ma = {kp_q[W-1], kp_q};
				mb = {err_q[W-1], err_q};
			end
			pid_pkg::ST_MUL_DT: begin
				ma = {err_q[W-1], err_q};
				mb = $signed({1'b0, dt_q});
			end
			// I product is held while the divider runs
			pid_pkg::ST_MUL_I, pid_pkg::ST_DIV: begin
				ma = {ki_q[W-1], ki_q};
				mb = {isum_q[W-1], isum_q};
				dstart = (st_q == pid_pkg::ST_MUL_I);
			end
			pid_pkg::ST_MUL_A: begin
				ma = {filt_q[W-1], filt_q};
				mb = $signed((W+1)'(al_q));
				msh = 6'(pid_pkg::ALPHA_BITS);
			end
			pid_pkg::ST_MUL_B: begin
				ma = {slope_q[W-1], slope_q};
				mb = $signed((W+1)'(17'h10000 - {1'b0, al_q}));
				msh = 6'(pid_pkg::ALPHA_BITS);
			end
			pid_pkg::ST_MUL_D: begin
				ma = {kd_q[W-1], kd_q};
				mb = {filt_q[W-1], filt_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pid_pkg::ST_IDLE;
			m_tvalid <= 1'b0;
			kp_q <= '0;
			ki_q <= '0;
			kd_q <= '0;
			dz_q <= '0;
			ib_q <= '1;
			ob_q <= '1;
			sb_q <= '1;
			al_q <= '0;
			isum_q <= '0;
			last_q <= '0;
			lv_q <= 1'b0;
			filt_q <= '0;
		end else begin
			st_q <= st_d;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (cfg_we) begin
				unique case (pid_pkg::reg_t'(cfg_index))
					pid_pkg::REG_GAIN_P: kp_q <= $signed(cfg_data);
					pid_pkg::REG_GAIN_I: ki_q <= $signed(cfg_data);
					pid_pkg::REG_GAIN_D: kd_q <= $signed(cfg_data);
					pid_pkg::REG_DEAD:   dz_q <= cfg_data[W-2:0];
					pid_pkg::REG_IBOUND: begin
						ib_q <= cfg_data[W-2:0];
						isum_q <= clampa(isum_q, cfg_data[W-2:0]);
					end
					pid_pkg::REG_OBOUND: ob_q <= cfg_data[W-2:0];
					pid_pkg::REG_SBOUND: sb_q <= cfg_data[W-2:0];
					pid_pkg::REG_SMOOTH:
						al_q <= (cfg_data[15:0] > pid_pkg::ALPHA_MAX) ?
							pid_pkg::ALPHA_MAX : cfg_data[15:0];
					default: ;
				endcase
			end
			unique case (st_q)
				pid_pkg::ST_ERR: begin
					if (op_q == pid_pkg::OP_CLEAR) begin
						isum_q <= '0;
						last_q <= '0;
						lv_q <= 1'b0;
						filt_q <= '0;
					end else if (op_q != pid_pkg::OP_NONE && !lv_q) begin
						last_q <= (op_q == pid_pkg::OP_STEP_SP) ?
							ssub(tgt_q, meas_q) : dir_q;
						lv_q <= 1'b1;
					end
				end
				pid_pkg::ST_MUL_P:
					if (emag < {1'b0, dz_q}) last_q <= err_q;
				pid_pkg::ST_INT: isum_q <= clampa(sadd(isum_q, mp), ib_q);
				pid_pkg::ST_SLOPE: last_q <= err_q;
				pid_pkg::ST_FILT: filt_q <= sadd(acc_q, mp);
				pid_pkg::ST_OUT: m_tvalid <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tgt_q  <= $signed(s_tdata[W-1:0]);
			meas_q <= $signed(s_tdata[2*W-1:W]);
			dir_q  <= $signed(s_tdata[3*W-1:2*W]);
			dt_q   <= (s_tdata[4*W-1:3*W] == '0) ? W'(1) : s_tdata[4*W-1:3*W];
			op_q   <= s_tuser;
			m_tdata <= '0;
		end
		unique case (st_q)
			pid_pkg::ST_ERR:
				err_q <= (op_q == pid_pkg::OP_STEP_SP) ? ssub(tgt_q, meas_q) : dir_q;
			pid_pkg::ST_MUL_DT: p_q <= mp;
			pid_pkg::ST_DIV: begin
				if (ddone) begin
					slope_q <= clampa(dq, sb_q);
					i_q <= mp;
				end
			end
			pid_pkg::ST_MUL_B: acc_q <= mp;
			pid_pkg::ST_MUL_D: i_q <= sadd(p_q, i_q);
			pid_pkg::ST_SUM: m_tdata <= clampa(sadd(i_q, mp), ob_q);
			default: ;
		endcase
	end
endmodule

FILE: test/pid_controller_step_tb.sv
// pid_controller_step_tb: self-checking testbench for the PID step block.
// Drives items over the stream port, predicts every drive value in its own
// fixed-point model and compares each result transfer. Depends on pid_pkg and pid_controller_step.
module pid_controller_step_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;
	localparam int HOLD_LEN = 400;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [31:0]  m_tdata;

	pid_controller_step i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copies of configuration and state
	longint kp, ki, kd, dband, ibnd, obnd, sbnd, alpha;
	longint acc_int, prev_err, slope_filt;
	bit     prev_ok;

	logic [31:0] drive_q[$];
	int          err_count = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          hold_req = 0;
	int          hold_ack = 0;
	int          hold_cycles = 0;

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		err_count++;
		$display("mismatch: %s got %h expected %h", what, got, want);
	endtask

	function automatic longint sat32(longint v);
		if (v > WMAX) return WMAX;
		if (v < WMIN) return WMIN;
		return v;
	endfunction

	function automatic longint clamp_abs(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint mul_trunc(longint a, longint b, int sh);
		logic [127:0] x, y, r;
		logic [127:0] lim;
		bit neg;
		neg = (a < 0) != (b < 0);
		x = (a < 0) ? 128'(-a) : 128'(a);
		y = (b < 0) ? 128'(-b) : 128'(b);
		r = (x * y) >> sh;
		lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		if (r > lim) r = lim;
		return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
	endfunction

	function automatic longint slope_div(longint n, longint d);
		logic [63:0] u, q;
		u = (n < 0) ? 64'(-n) : 64'(n);
		q = (u << 16) / 64'(d);
		if (q > 64'h8000_0000) q = 64'h8000_0000;
		return sat32((n < 0) ? -longint'(q) : longint'(q));
	endfunction

	function automatic logic [31:0] predict_drive(pid_pkg::op_t op, logic [31:0] t,
			logic [31:0] m, logic [31:0] e, logic [31:0] dt_in);
		longint err, dt, p, i, d, slope, sum;
		if (op == pid_pkg::OP_CLEAR) begin
			acc_int = 0; prev_err = 0; prev_ok = 0; slope_filt = 0;
			return '0;
		end
		if (op == pid_pkg::OP_NONE) return '0;
		if (op == pid_pkg::OP_STEP_SP)
			err = sat32(longint'($signed(t)) - longint'($signed(m)));
		else err = longint'($signed(e));
		dt = longint'(dt_in);
		if (dt == 0) dt = 1;
		if (!prev_ok) begin
			prev_err = err;
			prev_ok = 1;
		end
		if (((err < 0) ? -err : err) < dband) begin
			prev_err = err;
			return '0;
		end
		p = mul_trunc(kp, err, 16);
		acc_int = clamp_abs(sat32(acc_int + mul_trunc(err, dt, 16)), ibnd);
		i = mul_trunc(ki, acc_int, 16);
		slope = clamp_abs(slope_div(sat32(err - prev_err), dt), sbnd);
		prev_err = err;
		slope_filt = sat32(mul_trunc(slope_filt, alpha, pid_pkg::ALPHA_BITS)
			+ mul_trunc(slope, 65536 - alpha, pid_pkg::ALPHA_BITS));
		d = mul_trunc(kd, slope_filt, 16);
		sum = clamp_abs(sat32(sat32(p + i) + d), obnd);
		return sum[31:0];
	endfunction

	task automatic write_reg(pid_pkg::reg_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pid_pkg::REG_GAIN_P: kp = longint'($signed(val));
			pid_pkg::REG_GAIN_I: ki = longint'($signed(val));
			pid_pkg::REG_GAIN_D: kd = longint'($signed(val));
			pid_pkg::REG_DEAD:   dband = longint'(val[30:0]);
			pid_pkg::REG_IBOUND: begin
				ibnd = longint'(val[30:0]);
				acc_int = clamp_abs(acc_int, ibnd);
			end
			pid_pkg::REG_OBOUND: obnd = longint'(val[30:0]);
			pid_pkg::REG_SBOUND: sbnd = longint'(val[30:0]);
			pid_pkg::REG_SMOOTH: alpha = (val[15:0] > pid_pkg::ALPHA_MAX) ?
				longint'(pid_pkg::ALPHA_MAX) : longint'(val[15:0]);
		endcase
	endtask

	// wait for every pending drive value, then let the sequencer settle
	task automatic drain();
		while (drive_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic send_item(pid_pkg::op_t op, logic [31:0] t, logic [31:0] m,
			logic [31:0] e, logic [31:0] dt);
		int gap;
		gap = 0;
		if (idle_pct > 0) while ($urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {dt, e, m, t};
		forever begin
			@(negedge clk);
			if (s_tready) break;
			@(posedge clk);
		end
		@(posedge clk);
		drive_q.push_back(predict_drive(op, t, m, e, dt));
	endtask

	task automatic end_burst();
		@(posedge clk);
		s_tvalid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_cycles <= HOLD_LEN;
			m_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		logic [31:0] want;
		forever begin
			@(negedge clk);
			if (m_tvalid && m_tready) begin
				if (drive_q.size() == 0) begin
					report("unexpected transfer", m_tdata, '0);
				end else begin
					want = drive_q.pop_front();
					if (m_tdata !== want) report("drive", m_tdata, want);
				end
			end
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
			3: return 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_dt();
		case ($urandom_range(5))
			0: return '0;
			1: return 32'hffff_ffff;
			2: return $urandom;
			default: return 32'($urandom_range(1, 1 << 17));
		endcase
	endfunction

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
		endcase
	endfunction

	function automatic logic [31:0] rand_bound();
		case ($urandom_range(5))
			0: return 32'h7fff_ffff;
			1: return '0;
			2: return $urandom;
			default: return 32'($urandom_range(1, 1 << 24));
		endcase
	endfunction

	task automatic random_config();
		drain();
		write_reg(pid_pkg::REG_GAIN_P, rand_gain());
		write_reg(pid_pkg::REG_GAIN_I, rand_gain());
		write_reg(pid_pkg::REG_GAIN_D, rand_gain());
		write_reg(pid_pkg::REG_DEAD,
			($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(0, 1 << 16)));
		write_reg(pid_pkg::REG_IBOUND, rand_bound());
		write_reg(pid_pkg::REG_OBOUND, rand_bound());
		write_reg(pid_pkg::REG_SBOUND, rand_bound());
		write_reg(pid_pkg::REG_SMOOTH, ($urandom_range(3) == 0) ? 32'hffff : $urandom);
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(99);
		if (r < 3)
			send_item(pid_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
		else if (r < 5)
			send_item(pid_pkg::OP_NONE, $urandom, $urandom, $urandom, $urandom);
		else if (r < 50)
			send_item(pid_pkg::OP_STEP_SP, rand_word(), rand_word(), $urandom, rand_dt());
		else
			send_item(pid_pkg::OP_STEP_ERR, $urandom, $urandom, rand_word(), rand_dt());
	endtask

	task automatic test_reset_defaults();
		send_item(pid_pkg::OP_STEP_SP, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);
		send_item(pid_pkg::OP_STEP_ERR, 32'h0, 32'h0, 32'h8000_0000, 32'h0);
		end_burst();
	endtask

	task automatic test_directed();
		drain();
		write_reg(pid_pkg::REG_GAIN_P, 32'h0001_0000);
		write_reg(pid_pkg::REG_GAIN_I, 32'h0000_8000);
		write_reg(pid_pkg::REG_GAIN_D, 32'h0000_4000);
		write_reg(pid_pkg::REG_SMOOTH, 32'h0000_8000);
		send_item(pid_pkg::OP_STEP_SP, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0001_0000);
		send_item(pid_pkg::OP_STEP_SP, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0);
		send_item(pid_pkg::OP_STEP_ERR, 32'h0, 32'h0, 32'h7fff_ffff, 32'hffff_ffff);
		send_item(pid_pkg::OP_STEP_ERR, 32'h0, 32'h0, 32'h8000_0000, 32'h0);
		send_item(pid_pkg::OP_NONE, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
		send_item(pid_pkg::OP_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0);
		send_item(pid_pkg::OP_STEP_ERR, 32'h0, 32'h0, 32'h0002_0000, 32'h0000_1000);
		send_item(pid_pkg::OP_STEP_ERR, 32'h0, 32'h0, 32'hfffe_0000, 32'h0000_0001);
		end_burst();
		drain();
		write_reg(pid_pkg::REG_DEAD, 32'h0001_0000);
		write_reg(pid_pkg::REG_IBOUND, 32'h0000_0100);
		write_reg(pid_pkg::REG_SBOUND, 32'h0000_0000);
		write_reg(pid_pkg::REG_OBOUND, 32'h0002_0000);
		write_reg(pid_pkg::REG_SMOOTH, 32'hffff_ffff);
		send_item(pid_pkg::OP_STEP_ERR, 32'h0, 32'h0, 32'h0000_0100, 32'h0001_0000);
		send_item(pid_pkg::OP_STEP_SP, 32'h0000_8000, 32'h0000_8001, 32'h0, 32'h0001_0000);
		send_item(pid_pkg::OP_STEP_ERR, 32'h0, 32'h0, 32'h0010_0000, 32'h0001_0000);
		send_item(pid_pkg::OP_STEP_ERR, 32'h0, 32'h0, 32'hfff0_0000, 32'h0000_0000);
		end_burst();
		drain();
		write_reg(pid_pkg::REG_GAIN_P, 32'h8000_0000);
		write_reg(pid_pkg::REG_GAIN_I, 32'h7fff_ffff);
		write_reg(pid_pkg::REG_GAIN_D, 32'h8000_0000);
		write_reg(pid_pkg::REG_DEAD, 32'h7fff_ffff);
		send_item(pid_pkg::OP_STEP_ERR, 32'h0, 32'h0, 32'h7fff_0000, 32'h0001_0000);
		end_burst();
		drain();
		write_reg(pid_pkg::REG_DEAD, 32'h0);
		write_reg(pid_pkg::REG_IBOUND, 32'h7fff_ffff);
		write_reg(pid_pkg::REG_SBOUND, 32'h7fff_ffff);
		write_reg(pid_pkg::REG_OBOUND, 32'h7fff_ffff);
		write_reg(pid_pkg::REG_SMOOTH, 32'h0);
		send_item(pid_pkg::OP_STEP_ERR, 32'h0, 32'h0, 32'h7fff_ffff, 32'hffff_ffff);
		send_item(pid_pkg::OP_STEP_ERR, 32'h0, 32'h0, 32'h8000_0000, 32'h0);
		end_burst();
	endtask

	task automatic test_random_phases();
		int phase;
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 59; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 59; end
				default: begin idle_pct = 6; stall_pct = 6; end
			endcase
			random_config();
			repeat (140) random_item();
			end_burst();
		end
	endtask

	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		random_config();
		hold_req++;
		repeat (20) random_item();
		end_burst();
		drain();
		repeat (20) random_item();
		end_burst();
	endtask

	initial begin
		kp = 0; ki = 0; kd = 0; dband = 0;
		ibnd = WMAX; obnd = WMAX; sbnd = WMAX; alpha = 0;
		acc_int = 0; prev_err = 0; prev_ok = 0; slope_filt = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed();
		test_random_phases();
		test_backpressure();
		drain();
		repeat (100) @(posedge clk);
		if (err_count == 0 && drive_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule
